@@ rtl/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and constants shared by the delta-list timer queue and its memory.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int KW          = $clog2(MAX_RESULTS);

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_RELEASED  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] delta;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_REL_RD,
        S_REL_CHK,
        S_EMIT
    } t_state;

endpackage

@@ rtl/dtq_mem.sv @@
// ----------------------------------------------------------------------------
// dtq_mem
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dtq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  dtq_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output dtq_pkg::t_entry o_rdata
);
    import dtq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/delta_timer_queue.sv @@
// ----------------------------------------------------------------------------
// delta_timer_queue
// Sleep queue kept as a delta list in a circular entry memory.
// ----------------------------------------------------------------------------
// Usage: a command (tick, insert, remove) is a transfer on the input channel
// (i_valid, o_stall); results leave on the output channel (o_valid, i_stall),
// one per transfer, the final one of each command flagged by o_last.
// One command is worked at a time; o_stall is high while it runs.
// Entries live in a one-port-read, one-port-write memory with registered
// read data, used as a ring so that releasing the head only moves a pointer.
// Steps per command:
//   insert: scan for the place, move each later entry back, write it.
//   remove: scan for the id, move each later entry forward.
//   tick:   read the head, then count it down, or release it and each
//           following entry whose delta is zero.
// A result waits in the output register while i_stall is high; the
// sequencer waits with it, and a new command is taken once the final result
// of the last one is registered. Reset empties the queue; the
// memory keeps its contents, which are never read before being written.
// ----------------------------------------------------------------------------
module delta_timer_queue #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_item_id,
    input  logic [15:0] i_delay,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_released_id,
    output logic        o_last
);
    import dtq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_state         r_state, n_state;
    logic [1:0]     r_cmd, n_cmd;
    logic [15:0]    r_id, n_id;
    logic [15:0]    r_t, n_t;
    logic [CW-1:0]  r_idx, n_idx;
    logic [16:0]    r_sum, n_sum;
    logic [CW-1:0]  r_pos, n_pos;
    logic [15:0]    r_nd, n_nd;
    logic [15:0]    r_dadj, n_dadj;
    logic [AW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic [KW-1:0]  r_k, n_k;
    logic [15:0]    r_hid, n_hid;
    logic [15:0]    r_nid, n_nid;
    logic [1:0]     r_e_status, n_e_status;
    logic [15:0]    r_e_rid, n_e_rid;
    logic           r_e_last, n_e_last;
    logic           r_e_rel, n_e_rel;
    logic           r_ov, n_ov;
    logic [1:0]     r_status, n_status;
    logic [15:0]    r_rid, n_rid;
    logic           r_last, n_last;

    logic           mem_we, mem_re;
    logic [CW-1:0]  wr_log, rd_log;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    t_entry         mem_wdata, rdat;

    logic           in_xfer, slot_free, full, idx_end, ins_go, rel_more;
    logic           ins_shift_end, rem_more_first, rem_more_next;
    logic [17:0]    sum_d;
    logic [15:0]    nd_calc;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] lg);
        logic [AW+1:0] s;
        s = (AW+2)'(head) + (AW+2)'(lg);
        if (s >= (AW+2)'(CAPACITY)) begin
            s = s - (AW+2)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    assign in_xfer   = i_valid && !o_stall;
    assign slot_free = !r_ov || !i_stall;
    assign full      = (r_count == CW'(CAPACITY));
    assign idx_end   = (r_idx == r_count);
    assign sum_d     = {1'b0, r_sum} + 18'(rdat.delta);
    assign ins_go    = ({2'b00, r_t} > sum_d);
    assign nd_calc   = r_t - r_sum[15:0];
    assign rel_more  = (r_count > CW'(1)) && (r_k != KW'(MAX_RESULTS - 1));
    assign ins_shift_end  = (r_idx == r_pos + CW'(1));
    assign rem_more_first = ((CW+1)'(r_idx) + (CW+1)'(1)) < (CW+1)'(r_count);
    assign rem_more_next  = ((CW+1)'(r_idx) + (CW+1)'(2)) < (CW+1)'(r_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_command == CMD_TICK && r_count != '0) begin
                        n_state = S_HEAD_RD;
                    end else if ((i_command == CMD_INSERT && !full) ||
                                 i_command == CMD_REMOVE) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN_RD: begin
                if (!idx_end) begin
                    n_state = S_SCAN_CHK;
                end else if (r_cmd == CMD_INSERT) begin
                    n_state = S_INS_WR;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN_CHK: begin
                if (r_cmd == CMD_INSERT) begin
                    if (ins_go) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_SH_RD;
                    end
                end else if (rdat.id == r_id) begin
                    n_state = rem_more_first ? S_SH_RD : S_EMIT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: begin
                if (r_cmd == CMD_INSERT) begin
                    n_state = ins_shift_end ? S_INS_WR : S_SH_RD;
                end else begin
                    n_state = rem_more_next ? S_SH_RD : S_EMIT;
                end
            end
            S_INS_WR:   n_state = S_EMIT;
            S_HEAD_RD:  n_state = S_HEAD_CHK;
            S_HEAD_CHK: n_state = (rdat.delta > 16'd1) ? S_EMIT : S_REL_RD;
            S_REL_RD:   n_state = rel_more ? S_REL_CHK : S_EMIT;
            S_REL_CHK:  n_state = S_EMIT;
            S_EMIT: begin
                if (slot_free) begin
                    n_state = r_e_last ? S_IDLE : S_REL_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and output register.
    always_comb begin
        n_cmd      = r_cmd;
        n_id       = r_id;
        n_t        = r_t;
        n_idx      = r_idx;
        n_sum      = r_sum;
        n_pos      = r_pos;
        n_nd       = r_nd;
        n_dadj     = r_dadj;
        n_head     = r_head;
        n_count    = r_count;
        n_k        = r_k;
        n_hid      = r_hid;
        n_nid      = r_nid;
        n_e_status = r_e_status;
        n_e_rid    = r_e_rid;
        n_e_last   = r_e_last;
        n_e_rel    = r_e_rel;
        n_ov       = r_ov && i_stall;
        n_status   = r_status;
        n_rid      = r_rid;
        n_last     = r_last;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        wr_log     = r_idx;
        rd_log     = r_idx;
        mem_wdata  = rdat;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd      = i_command;
                    n_id       = i_item_id;
                    n_t        = (i_delay == 16'd0) ? 16'd1 : i_delay;
                    n_idx      = '0;
                    n_sum      = '0;
                    n_e_rid    = '0;
                    n_e_last   = 1'b1;
                    n_e_rel    = 1'b0;
                    n_e_status = (i_command == CMD_INSERT && full) ? ST_FULL : ST_DONE;
                end
            end
            S_SCAN_RD: begin
                if (!idx_end) begin
                    mem_re = 1'b1;
                end else if (r_cmd == CMD_INSERT) begin
                    n_pos = r_count;
                    n_nd  = nd_calc;
                end else begin
                    n_e_status = ST_NOT_FOUND;
                end
            end
            S_SCAN_CHK: begin
                if (r_cmd == CMD_INSERT) begin
                    if (ins_go) begin
                        n_sum = sum_d[16:0];
                        n_idx = r_idx + CW'(1);
                    end else begin
                        n_pos = r_idx;
                        n_nd  = nd_calc;
                        n_idx = r_count;
                    end
                end else if (rdat.id == r_id) begin
                    n_pos  = r_idx;
                    n_dadj = rdat.delta;
                    if (!rem_more_first) begin
                        n_count = r_count - CW'(1);
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_SH_RD: begin
                mem_re = 1'b1;
                rd_log = (r_cmd == CMD_INSERT) ? r_idx - CW'(1) : r_idx + CW'(1);
            end
            S_SH_WR: begin
                mem_we   = 1'b1;
                wr_log   = r_idx;
                mem_wdata.id = rdat.id;
                if (r_cmd == CMD_INSERT) begin
                    mem_wdata.delta = ins_shift_end ? rdat.delta - r_nd : rdat.delta;
                    n_idx = r_idx - CW'(1);
                end else begin
                    mem_wdata.delta = (r_idx == r_pos) ? rdat.delta + r_dadj
                                                       : rdat.delta;
                    n_idx = r_idx + CW'(1);
                    if (!rem_more_next) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_INS_WR: begin
                mem_we          = 1'b1;
                wr_log          = r_pos;
                mem_wdata.id    = r_id;
                mem_wdata.delta = r_nd;
                n_count         = r_count + CW'(1);
            end
            S_HEAD_RD: begin
                mem_re = 1'b1;
                rd_log = '0;
            end
            S_HEAD_CHK: begin
                n_hid = rdat.id;
                n_k   = '0;
                if (rdat.delta > 16'd1) begin
                    mem_we          = 1'b1;
                    wr_log          = '0;
                    mem_wdata.id    = rdat.id;
                    mem_wdata.delta = rdat.delta - 16'd1;
                end
            end
            S_REL_RD: begin
                n_e_status = ST_RELEASED;
                n_e_rid    = r_hid;
                n_e_rel    = 1'b1;
                n_e_last   = 1'b1;
                if (rel_more) begin
                    mem_re = 1'b1;
                    rd_log = CW'(1);
                end
            end
            S_REL_CHK: begin
                n_nid    = rdat.id;
                n_e_last = (rdat.delta != 16'd0);
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ov     = 1'b1;
                    n_status = r_e_status;
                    n_rid    = r_e_rid;
                    n_last   = r_e_last;
                    if (r_e_rel) begin
                        n_head  = phys(r_head, CW'(1));
                        n_count = r_count - CW'(1);
                        n_k     = r_k + KW'(1);
                        n_hid   = r_nid;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign mem_waddr = phys(r_head, wr_log);
    assign mem_raddr = phys(r_head, rd_log);

    dtq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rdat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_t        <= n_t;
        r_idx      <= n_idx;
        r_sum      <= n_sum;
        r_pos      <= n_pos;
        r_nd       <= n_nd;
        r_dadj     <= n_dadj;
        r_k        <= n_k;
        r_hid      <= n_hid;
        r_nid      <= n_nid;
        r_e_status <= n_e_status;
        r_e_rid    <= n_e_rid;
        r_e_last   <= n_e_last;
        r_e_rel    <= n_e_rel;
        r_status   <= n_status;
        r_rid      <= n_rid;
        r_last     <= n_last;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_status      = r_status;
    assign o_released_id = r_rid;
    assign o_last        = r_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + CW'(1) ||
                            r_count + CW'(1) == $past(r_count)))
        else $error("entry count moved by more than one");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re && mem_waddr == mem_raddr))
        else $error("read and write of the same entry in one cycle");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_RELEASED) |-> o_last)
        else $error("non-release result not flagged last");
`endif

endmodule
